// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator package
// Types, codes and fixed widths shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

   // Fixed field widths
   localparam int CNT_W    = 8;
   localparam int FRAME_W  = 12;
   localparam int LEN_W    = 13;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIXED  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_BUMP,
      ST_RESP
   } state_type;

   // Count memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pfa_count_mem.sv =====
// ----------------------------------------------------------------------------
// Reference count memory
// One count per frame; one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_count_mem #(
   parameter int NUM_FRAMES = 4096
) (
   input  wire logic                               clock,
   input  wire pfa_pkg::mem_ctl_type               mem_ctl,
   input  wire logic [$clog2(NUM_FRAMES)-1:0]      wr_addr,
   input  wire logic [pfa_pkg::CNT_W-1:0]          wr_data,
   input  wire logic [$clog2(NUM_FRAMES)-1:0]      rd_addr,
   output logic      [pfa_pkg::CNT_W-1:0]          rd_data
);
   import pfa_pkg::*;

   logic [CNT_W-1:0] mem [NUM_FRAMES];
   logic [CNT_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_count_alu.sv =====
// ----------------------------------------------------------------------------
// Reference count unit
// Zero test and saturating increment or decrement of one count.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_count_alu (
   input  wire logic [pfa_pkg::CNT_W-1:0] count_value,
   input  wire logic                      up,
   output logic                           is_zero,
   output logic      [pfa_pkg::CNT_W-1:0] next_value
);
   import pfa_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   assign is_zero = (count_value == '0);

   // Step the count, holding at both ends
   always_comb begin
      next_value = count_value;
      if (up) begin
         if (count_value != CNT_MAX) begin
            next_value = count_value + CNT_W'(1);
         end
      end else begin
         if (!is_zero) begin
            next_value = count_value - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Clears the counts after reset, scans for free runs and steps run counts.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl #(
   parameter int NUM_FRAMES = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [pfa_pkg::CMD_W-1:0]          req_command,
   input  wire logic [pfa_pkg::FRAME_W-1:0]        req_frame_number,
   input  wire logic [pfa_pkg::LEN_W-1:0]          req_frame_count,
   // response
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [pfa_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [pfa_pkg::FRAME_W-1:0]        rsp_first_frame,
   // count memory and count unit
   output pfa_pkg::mem_ctl_type                    mem_ctl,
   output logic      [$clog2(NUM_FRAMES)-1:0]      wr_addr,
   output logic      [pfa_pkg::CNT_W-1:0]          wr_data,
   output logic      [$clog2(NUM_FRAMES)-1:0]      rd_addr,
   output logic                                    alu_up,
   input  wire logic                               alu_is_zero,
   input  wire logic [pfa_pkg::CNT_W-1:0]          alu_next_value
);
   import pfa_pkg::*;

   localparam int FW = $clog2(NUM_FRAMES);
   localparam int XW = (FW + 1 > LEN_W + 1) ? FW + 1 : LEN_W + 1;
   localparam logic [XW-1:0] NUM_X  = XW'(NUM_FRAMES);
   localparam logic [XW-1:0] LAST_X = XW'(NUM_FRAMES - 1);

   state_type             state_ff, state_in;
   logic [XW-1:0]         pos_ff, pos_in;
   logic [XW-1:0]         cnt_ff, cnt_in;
   logic [XW-1:0]         run_ff, run_in;
   logic [XW-1:0]         first_ff, first_in;
   logic [FW-1:0]         rdpos_ff, rdpos_in;
   logic                  rdv_ff, rdv_in;
   logic                  up_ff, up_in;
   logic                  pass2_ff, pass2_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0]    rsp_first_ff, rsp_first_in;
   logic                  issue;
   logic [XW-1:0]         req_frame_x;
   logic [XW-1:0]         req_count_x;

   assign req_frame_x = XW'(req_frame_number);
   assign req_count_x = XW'(req_frame_count);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      run_ff        <= run_in;
      first_ff      <= first_in;
      rdpos_ff      <= rdpos_in;
      up_ff         <= up_in;
      pass2_ff      <= pass2_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
   end

   // Next state and memory strobes
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      run_in        = run_ff;
      first_in      = first_ff;
      rdpos_in      = rdpos_ff;
      rdv_in        = rdv_ff;
      up_in         = up_ff;
      pass2_in      = pass2_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      mem_ctl       = '0;
      wr_addr       = rdpos_ff;
      wr_data       = alu_next_value;
      rd_addr       = pos_ff[FW-1:0];
      req_tready    = 1'b0;
      issue         = 1'b0;

      case (state_ff)
         // Sweep zeros through the count memory
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = pos_ff[FW-1:0];
            wr_data       = '0;
            if (pos_ff == LAST_X) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + XW'(1);
            end
         end

         // Take a request and decode it
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               up_in    = (req_command == CMD_FIXED);
               cnt_in   = req_count_x;
               pos_in   = req_frame_x;
               run_in   = '0;
               rdv_in   = 1'b0;
               first_in = '0;
               pass2_in = (req_frame_number != '0);
               case (req_command)
                  CMD_SEARCH: begin
                     if (req_frame_count == '0) begin
                        status_in = STAT_DONE;
                        first_in  = req_frame_x;
                        state_in  = ST_RESP;
                     end else if (req_count_x > NUM_X) begin
                        status_in = STAT_RANGE;
                        state_in  = ST_RESP;
                     end else begin
                        up_in    = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_FIXED, CMD_FREE: begin
                     if (req_frame_x + req_count_x > NUM_X) begin
                        status_in = STAT_RANGE;
                        state_in  = ST_RESP;
                     end else begin
                        status_in = STAT_DONE;
                        if (req_command == CMD_FIXED) begin
                           first_in = req_frame_x;
                        end
                        state_in = ST_BUMP;
                     end
                  end
                  default: begin
                     status_in = STAT_RANGE;
                     state_in  = ST_RESP;
                  end
               endcase
            end
         end

         // Read one count per cycle and track the current free run
         ST_SCAN: begin
            issue = (pos_ff < NUM_X);
            if (issue) begin
               mem_ctl.rd_en = 1'b1;
               pos_in        = pos_ff + XW'(1);
            end
            rdv_in   = issue;
            rdpos_in = pos_ff[FW-1:0];
            if (rdv_ff) begin
               if (alu_is_zero) begin
                  if (run_ff == '0) begin
                     first_in = XW'(rdpos_ff);
                  end
                  run_in = run_ff + XW'(1);
                  if (run_ff + XW'(1) >= cnt_ff) begin
                     // Run complete: step it from its first frame
                     status_in = STAT_DONE;
                     pos_in    = (run_ff == '0) ? XW'(rdpos_ff) : first_ff;
                     rdv_in    = 1'b0;
                     state_in  = ST_BUMP;
                  end
               end else begin
                  run_in = '0;
               end
            end else if (!issue) begin
               if (pass2_ff) begin
                  // Wrap once to frame zero
                  pos_in   = '0;
                  run_in   = '0;
                  pass2_in = 1'b0;
               end else begin
                  status_in = STAT_NOT_FOUND;
                  first_in  = '0;
                  state_in  = ST_RESP;
               end
            end
         end

         // Read, adjust and write back one count per cycle
         ST_BUMP: begin
            if (cnt_ff != '0) begin
               mem_ctl.rd_en = 1'b1;
               pos_in        = pos_ff + XW'(1);
               cnt_in        = cnt_ff - XW'(1);
               rdv_in        = 1'b1;
               rdpos_in      = pos_ff[FW-1:0];
            end else begin
               rdv_in = 1'b0;
            end
            if (rdv_ff) begin
               mem_ctl.wr_en = 1'b1;
            end
            if (cnt_ff == '0 && !rdv_ff) begin
               state_in = ST_RESP;
            end
         end

         // Hand the result to the output register once it is free
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_first_in  = first_ff[FRAME_W-1:0];
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign alu_up          = up_ff;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_first_frame = rsp_first_ff;

`include "assert_macros.svh"

   `ASSERT_CLK_RST(a_rw_apart, clock, reset,
      (mem_ctl.wr_en && mem_ctl.rd_en) |-> (wr_addr != rd_addr),
      "count memory read and write hit the same frame")
   `ASSERT_CLK_RST(a_one_at_a_time, clock, reset,
      (req_tvalid && req_tready) |=> !req_tready,
      "request taken while another is in progress")
   `ASSERT_CLK_RST(a_scan_bounds, clock, reset,
      (state_ff == ST_SCAN) |-> ((run_ff < cnt_ff) && (pos_ff <= NUM_X)),
      "scan run length or position out of bounds")
   `ASSERT_CLK_RST(a_no_write_idle, clock, reset,
      (state_ff == ST_IDLE || state_ff == ST_RESP) |-> !mem_ctl.wr_en,
      "count written outside clear or run update")

endmodule

`default_nettype wire

// ===== hw/rtl/page_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator
// Per-frame reference counts with first-fit run search, fixed allocate, free.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tuser: command; tdata: frame_number, frame_count
//  rsp_    | out       | tuser: status;  tdata: first_frame
//
//  After reset a clearing pass zeroes the counts;
//  req_tready stays low until it ends.
//  One request at a time, paced by the count memory's single read port:
//  a search scans the counts and then steps the run it found, a fixed
//  allocate or free steps its run, and other requests answer directly.
//  The result sits in an output register; a stalled rsp_ holds it while the
//  next request is already taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator #(
   parameter int NUM_FRAMES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [11:0] frame_number, [24:12] frame_count
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [11:0] first_frame
   output logic      [1:0]  rsp_tuser    // [1:0] status
);
   import pfa_pkg::*;

   localparam int FW = $clog2(NUM_FRAMES);

   mem_ctl_type          mem_ctl;
   logic [FW-1:0]        wr_addr;
   logic [FW-1:0]        rd_addr;
   logic [CNT_W-1:0]     wr_data;
   logic [CNT_W-1:0]     rd_data;
   logic                 alu_up;
   logic                 alu_is_zero;
   logic [CNT_W-1:0]     alu_next_value;
   logic [FRAME_W-1:0]   rsp_first_frame;

   pfa_ctrl #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_command      (req_tuser),
      .req_frame_number (req_tdata[11:0]),
      .req_frame_count  (req_tdata[24:12]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_status       (rsp_tuser),
      .rsp_first_frame  (rsp_first_frame),
      .mem_ctl          (mem_ctl),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr          (rd_addr),
      .alu_up           (alu_up),
      .alu_is_zero      (alu_is_zero),
      .alu_next_value   (alu_next_value)
   );

   pfa_count_mem #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_count_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfa_count_alu u_count_alu (
      .count_value (rd_data),
      .up          (alu_up),
      .is_zero     (alu_is_zero),
      .next_value  (alu_next_value)
   );

   // Pad the result to whole bytes
   assign rsp_tdata = {4'b0000, rsp_first_frame};

endmodule

`default_nettype wire

// ===== tb/page_frame_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Sends search, fixed allocate, free and unused-code requests over the req_
// stream, keeps its own copy of the per-frame reference counts to predict
// every response, and compares each rsp_ response field by field. Runs
// directed edge cases, count saturation, a long output stall and random
// traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator_tb;
   import pfa_pkg::*;

   localparam int FRAME_TOTAL = 4096;
   localparam int TAIL_CYCLES = 16;
   localparam int HOLD_CYCLES = 400;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  first_frame;
   } response_type;

   typedef struct {
      int unsigned frame;
      int unsigned count;
   } run_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [11:0] frame_number, [24:12] frame_count
   logic [1:0]  req_tuser = '0;    // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [11:0] first_frame
   logic [1:0]  rsp_tuser;         // [1:0] status

   // Shadow copy of the reference counts
   bit [CNT_W-1:0] frame_refs [FRAME_TOTAL];
   response_type   expected_responses [$];
   run_type        live_runs [$];
   int             error_count = 0;
   int             send_idle_pct = 0;
   int             reply_stall_pct = 0;
   logic           rsp_hold = 1'b0;
   int             random_sent = 0;

   page_frame_allocator #(
      .NUM_FRAMES (FRAME_TOTAL)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // First-fit scan for a free run from start up to the last frame
   function automatic void find_free_run(input int unsigned start, input int unsigned count,
                                         output bit found, output int unsigned at);
      int unsigned run_len;
      int unsigned run_start;
      run_len = 0;
      run_start = 0;
      found = 1'b0;
      at = 0;
      for (int unsigned f = start; f < FRAME_TOTAL; f++) begin
         if (frame_refs[f] != 0) begin
            run_len = 0;
         end else begin
            if (run_len == 0) run_start = f;
            run_len++;
            if (run_len >= count) begin
               found = 1'b1;
               at = run_start;
               return;
            end
         end
      end
   endfunction

   // Step counts of a run up or down, saturating at both ends
   function automatic void adjust_run(input int unsigned start, input int unsigned count,
                                      input bit up);
      int unsigned f;
      for (int unsigned i = 0; i < count; i++) begin
         f = start + i;
         if (f >= FRAME_TOTAL) break;
         if (up && frame_refs[f] != 8'd255) frame_refs[f]++;
         else if (!up && frame_refs[f] != 8'd0) frame_refs[f]--;
      end
   endfunction

   // Work out the response to one request and update the shadow counts
   function automatic response_type allocate_response(input logic [CMD_W-1:0] cmd,
                                                      input int unsigned frame,
                                                      input int unsigned count);
      response_type resp;
      bit           found;
      int unsigned  at;
      resp.status = STAT_RANGE;
      resp.first_frame = '0;
      if (cmd == CMD_SEARCH) begin
         if (count == 0) begin
            resp.status = STAT_DONE;
            resp.first_frame = frame[FRAME_W-1:0];
         end else if (count > FRAME_TOTAL) begin
            resp.status = STAT_RANGE;
         end else begin
            find_free_run(frame, count, found, at);
            if (!found && frame != 0) find_free_run(0, count, found, at);
            if (found) begin
               adjust_run(at, count, 1'b1);
               resp.status = STAT_DONE;
               resp.first_frame = at[FRAME_W-1:0];
            end else begin
               resp.status = STAT_NOT_FOUND;
            end
         end
      end else if (cmd == CMD_FIXED || cmd == CMD_FREE) begin
         if (frame + count <= FRAME_TOTAL) begin
            adjust_run(frame, count, cmd == CMD_FIXED);
            resp.status = STAT_DONE;
            resp.first_frame = (cmd == CMD_FIXED) ? frame[FRAME_W-1:0] : '0;
         end
      end
      return resp;
   endfunction

   // Offer one request, wait for the handshake, then queue its expected response
   task automatic send_request(input logic [CMD_W-1:0] cmd, input int unsigned frame,
                               input int unsigned count, output response_type resp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, count[LEN_W-1:0], frame[FRAME_W-1:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      resp = allocate_response(cmd, frame, count);
      expected_responses.push_back(resp);
   endtask

   task automatic issue(input logic [CMD_W-1:0] cmd, input int unsigned frame,
                        input int unsigned count);
      response_type resp;
      send_request(cmd, frame, count, resp);
   endtask

   // Drop valid and wait until every expected response has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Randomly stall the response side, or hold it off completely
   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= reply_stall_pct);
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response: status %0d first_frame %0d",
                   rsp_tuser, rsp_tdata[11:0]);
            error_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[11:0] !== want.first_frame) begin
               $error("first_frame: expected %0d, actual %0d",
                      want.first_frame, rsp_tdata[11:0]);
               error_count++;
            end
         end
      end
   end

   // Field extremes, every command and the corner cases of search and runs
   task automatic test_edge_cases();
      send_idle_pct = 0;
      reply_stall_pct = 0;
      issue(CMD_SEARCH, 4095, 0);         // empty run returns the hint
      issue(CMD_SEARCH, 0, 8191);         // longer than the frame range
      issue(CMD_SEARCH, 7, 4097);
      issue(CMD_SEARCH, 0, 4096);         // take every frame
      issue(CMD_SEARCH, 0, 1);            // full, hint zero: one pass only
      issue(CMD_SEARCH, 5, 1);            // full, both passes fail
      issue(CMD_FIXED, 0, 4096);          // fixed allocate on used frames
      issue(CMD_FREE, 0, 4096);
      issue(CMD_FREE, 0, 4096);
      issue(CMD_FREE, 10, 3);             // free of free frames stays at zero
      issue(CMD_FIXED, 4095, 2);          // runs past the last frame
      issue(CMD_FIXED, 1, 4096);
      issue(CMD_FREE, 4000, 100);
      issue(CMD_FIXED, 4095, 0);          // empty runs in range
      issue(CMD_FREE, 4095, 0);
      issue(CMD_UNUSED, 4095, 8191);
      issue(CMD_FIXED, 0, 10);
      issue(CMD_SEARCH, 0, 5);
      issue(CMD_FIXED, 20, 1);
      issue(CMD_SEARCH, 0, 6);            // hole too short, skip it
      issue(CMD_SEARCH, 0, 5);            // first fit lands in the hole
      issue(CMD_FIXED, 4090, 6);
      issue(CMD_SEARCH, 4095, 2);         // hint at the last frame wraps to zero
      issue(CMD_SEARCH, 4088, 2);
      issue(CMD_FREE, 0, 10);
      wait_drain();
   endtask

   // Stack a few references on a run, probe it, then free it down past zero
   task automatic test_count_saturation();
      send_idle_pct = 33;
      reply_stall_pct = 33;
      repeat (3) issue(CMD_FIXED, 4000, 8);
      issue(CMD_SEARCH, 4000, 8);
      repeat (4) issue(CMD_FREE, 4000, 8);
      issue(CMD_SEARCH, 4000, 8);
      wait_drain();
   endtask

   // Hold the response side off while requests keep coming
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      reply_stall_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            for (int i = 0; i < 8; i++) issue(CMD_FIXED, 3000 + i, 1);
         end
      join
      wait_drain();
   endtask

   // Random traffic: mostly searches and frees of runs handed out earlier
   task automatic test_random_mix(input int idle_pct, input int stall_pct, input int n_items);
      response_type     resp;
      logic [CMD_W-1:0] cmd;
      int unsigned      frame;
      int unsigned      count;
      int unsigned      pick;
      int               idx;
      send_idle_pct = idle_pct;
      reply_stall_pct = stall_pct;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         frame = $urandom_range(4095);
         count = $urandom_range(1, 48);
         if (pick < 45) begin
            cmd = CMD_SEARCH;
            pick = $urandom_range(99);
            if (pick < 7) count = 0;
            else if (pick < 12) count = $urandom_range(49, 1024);
            else if (pick < 15) count = $urandom_range(4000, 8191);
         end else if (pick < 70) begin
            cmd = CMD_FIXED;
            count = $urandom_range(0, 32);
            if ($urandom_range(9) == 0) frame = $urandom_range(4064, 4095);
         end else if (pick < 95) begin
            cmd = CMD_FREE;
            count = $urandom_range(0, 64);
            if (live_runs.size() != 0 && $urandom_range(9) < 7) begin
               idx = $urandom_range(live_runs.size() - 1);
               frame = live_runs[idx].frame;
               count = live_runs[idx].count;
               live_runs.delete(idx);
            end
         end else begin
            cmd = CMD_UNUSED;
            count = $urandom_range(8191);
         end
         send_request(cmd, frame, count, resp);
         random_sent++;
         // Remember granted runs so later frees release real allocations
         if (resp.status == STAT_DONE && count != 0 && (cmd == CMD_SEARCH || cmd == CMD_FIXED))
            live_runs.push_back('{frame: resp.first_frame, count: count});
      end
      wait_drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_count_saturation();
      test_output_backpressure();
      test_random_mix(0, 0, 15);
      test_random_mix(70, 0, 15);
      test_random_mix(0, 70, 15);
      test_random_mix(33, 33, 15);
      $display("Covered search, fixed, free and unused-code edge cases, counts held at zero,");
      $display("a %0d-cycle output stall and %0d random requests under four idle mixes.",
               HOLD_CYCLES, random_sent);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #40000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
